[sv/llt_pkg.sv]
// Shared types, constants and character-class functions for the lambda language tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

    localparam int OFFSET_BITS_DEF   = 32;
    localparam int LINE_COL_BITS_DEF = 16;
    localparam int INT_BITS_DEF      = 31;

    localparam int KIND_W   = 4;
    localparam int LEN_W    = 16;
    localparam int WINDOW_W = 40;

    typedef enum logic [KIND_W-1:0] {
        TK_EOF    = 4'd0,
        TK_LPAREN = 4'd1,
        TK_RPAREN = 4'd2,
        TK_LAMBDA = 4'd3,
        TK_DOT    = 4'd4,
        TK_LET    = 4'd5,
        TK_EQUALS = 4'd6,
        TK_IN     = 4'd7,
        TK_IDENT  = 4'd8,
        TK_INT    = 4'd9,
        TK_TRUE   = 4'd10,
        TK_FALSE  = 4'd11,
        TK_UNIT   = 4'd12,
        TK_ERROR  = 4'd13
    } tok_kind_t;

    typedef enum logic [4:0] {
        M_IDLE    = 5'b00001,
        M_COMMENT = 5'b00010,
        M_NUMBER  = 5'b00100,
        M_IDENT   = 5'b01000,
        M_ERROR   = 5'b10000
    } scan_mode_t;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

    localparam logic [WINDOW_W-1:0] KW_LET   = WINDOW_W'("let");
    localparam logic [WINDOW_W-1:0] KW_IN    = WINDOW_W'("in");
    localparam logic [WINDOW_W-1:0] KW_TRUE  = WINDOW_W'("true");
    localparam logic [WINDOW_W-1:0] KW_FALSE = WINDOW_W'("false");
    localparam logic [WINDOW_W-1:0] KW_UNIT  = WINDOW_W'("unit");

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER || b == CH_QUOTE;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b inside {CH_LPAREN, CH_RPAREN, CH_DOT, CH_EQUALS, CH_BSLASH};
    endfunction

    function automatic tok_kind_t punct_kind(input logic [7:0] b);
        tok_kind_t k;
        case (b)
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_DOT:    k = TK_DOT;
            CH_EQUALS: k = TK_EQUALS;
            default:   k = TK_LAMBDA;
        endcase
        return k;
    endfunction

    function automatic tok_kind_t word_kind(input logic [LEN_W-1:0] len,
                                            input logic [WINDOW_W-1:0] win);
        tok_kind_t k;
        k = TK_IDENT;
        if (len == LEN_W'(3) && win == KW_LET) begin
            k = TK_LET;
        end else if (len == LEN_W'(2) && win == KW_IN) begin
            k = TK_IN;
        end else if (len == LEN_W'(4) && win == KW_TRUE) begin
            k = TK_TRUE;
        end else if (len == LEN_W'(5) && win == KW_FALSE) begin
            k = TK_FALSE;
        end else if (len == LEN_W'(4) && win == KW_UNIT) begin
            k = TK_UNIT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/lambda_language_tokenizer_top.sv]
// Lambda language tokenizer: byte-serial lexical scanner with a small result queue.
// Tokens are registered into a four-entry result queue and shown on m_ from its head.
// Throughput: one byte per cycle while s_tready is high; it drops while fewer than
// two queue entries are free. A byte that ends a number or identifier and is itself a
// token yields two result beats, drained one beat per cycle while m_tready is high.
// Reset (aresetn low at aclk): scanner idle, counters to offset 0, line 1, column 1,
// queue empty.
`timescale 1ns / 1ps
`default_nettype none

module lambda_language_tokenizer_top #(
    parameter int OFFSET_BITS   = llt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_COL_BITS = llt_pkg::LINE_COL_BITS_DEF,
    parameter int INT_BITS      = llt_pkg::INT_BITS_DEF,
    localparam int M_DATA_W = ((INT_BITS + OFFSET_BITS + llt_pkg::LEN_W
                                + 2 * LINE_COL_BITS + 8 + 7) / 8) * 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // in_byte
    input  wire logic                      s_tlast,   // end_of_input
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // int_value, start_offset, token_length, err_line, err_column, err_char
    output logic [M_DATA_W-1:0]            m_tdata,
    output logic [llt_pkg::KIND_W-1:0]     m_tuser,   // token_kind
    output logic                           m_tlast    // last
);
    import llt_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0]               chr;
        logic [LINE_COL_BITS-1:0] col;
        logic [LINE_COL_BITS-1:0] line;
        logic [LEN_W-1:0]         len;
        logic [OFFSET_BITS-1:0]   start;
        logic [INT_BITS-1:0]      ival;
        tok_kind_t                kind;
        logic                     last;
    } result_t;

    scan_mode_t               mode_reg,  mode_next;
    logic [INT_BITS-1:0]      accum_reg, accum_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]         len_reg,   len_next;
    logic [WINDOW_W-1:0]      win_reg,   win_next;
    logic [OFFSET_BITS-1:0]   pos_reg,   pos_next;
    logic [LINE_COL_BITS-1:0] line_reg,  line_next;
    logic [LINE_COL_BITS-1:0] col_reg,   col_next;

    result_t             queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    logic                     s_acc, m_acc;
    logic [7:0]               b;
    logic [LINE_COL_BITS-1:0] col_inc, line_inc;
    logic [LEN_W-1:0]         len_inc;
    logic [INT_BITS+3:0]      acc_prod;
    logic [INT_BITS-1:0]      acc_step;
    result_t                  flush_res, tok, res0, res1, head;
    logic                     flush_on, tok_valid, scan;
    logic [1:0]               push_cnt;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign b        = s_tdata;
    assign col_inc  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + 1'b1;

    // saturating accum * 10 + digit
    assign acc_prod = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                      + (INT_BITS + 4)'(b - CH_ZERO);
    assign acc_step = (acc_prod > (INT_BITS + 4)'({INT_BITS{1'b1}}))
                      ? '1 : acc_prod[INT_BITS-1:0];

    always_comb begin
        flush_res = '0;
        if (mode_reg == M_NUMBER) begin
            flush_res.kind  = TK_INT;
            flush_res.ival  = accum_reg;
            flush_res.start = start_reg;
            flush_res.len   = len_reg;
        end else if (mode_reg == M_IDENT) begin
            flush_res.kind = word_kind(len_reg, win_reg);
            if (flush_res.kind == TK_IDENT) begin
                flush_res.start = start_reg;
                flush_res.len   = len_reg;
            end
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        start_next = start_reg;
        len_next   = len_reg;
        win_next   = win_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tok        = '0;
        tok_valid  = 1'b0;
        flush_on   = 1'b0;
        scan       = 1'b0;
        if (s_tlast) begin
            flush_on   = (mode_reg == M_NUMBER) || (mode_reg == M_IDENT);
            tok_valid  = 1'b1;
            tok.kind   = TK_EOF;
            mode_next  = M_IDLE;
            accum_next = '0;
            start_next = '0;
            len_next   = '0;
            win_next   = '0;
            pos_next   = '0;
            line_next  = LINE_COL_BITS'(1);
            col_next   = LINE_COL_BITS'(1);
        end else begin
            pos_next = pos_reg + 1'b1;
            case (mode_reg)
                M_IDLE: begin
                    scan = 1'b1;
                end
                M_COMMENT: begin
                    if (b == CH_LF) begin
                        mode_next = M_IDLE;
                        scan      = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(b)) begin
                        accum_next = acc_step;
                        len_next   = len_inc;
                        col_next   = col_inc;
                    end else begin
                        flush_on  = 1'b1;
                        mode_next = M_IDLE;
                        scan      = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(b)) begin
                        win_next = {win_reg[WINDOW_W-9:0], b};
                        len_next = len_inc;
                        col_next = col_inc;
                    end else begin
                        flush_on  = 1'b1;
                        mode_next = M_IDLE;
                        scan      = 1'b1;
                    end
                end
                M_ERROR: begin
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
            if (scan) begin
                if (is_blank(b)) begin
                    if (b == CH_LF) begin
                        line_next = line_inc;
                        col_next  = LINE_COL_BITS'(1);
                    end else begin
                        col_next = col_inc;
                    end
                end else if (b == CH_HASH) begin
                    mode_next = M_COMMENT;
                end else if (is_punct(b)) begin
                    tok_valid = 1'b1;
                    tok.kind  = punct_kind(b);
                    col_next  = col_inc;
                end else if (is_digit(b)) begin
                    mode_next  = M_NUMBER;
                    accum_next = INT_BITS'(b - CH_ZERO);
                    start_next = pos_reg;
                    len_next   = LEN_W'(1);
                    col_next   = col_inc;
                end else if (is_alpha(b) || b == CH_UNDER) begin
                    mode_next  = M_IDENT;
                    win_next   = WINDOW_W'(b);
                    start_next = pos_reg;
                    len_next   = LEN_W'(1);
                    col_next   = col_inc;
                end else begin
                    tok_valid = 1'b1;
                    tok.kind  = TK_ERROR;
                    tok.line  = line_reg;
                    tok.col   = col_reg;
                    tok.chr   = b;
                    mode_next = M_ERROR;
                end
            end
        end
    end

    always_comb begin
        res0     = '0;
        res1     = '0;
        push_cnt = 2'd0;
        if (flush_on && tok_valid) begin
            res0      = flush_res;
            res1      = tok;
            res1.last = 1'b1;
            push_cnt  = 2'd2;
        end else if (flush_on) begin
            res0      = flush_res;
            res0.last = 1'b1;
            push_cnt  = 2'd1;
        end else if (tok_valid) begin
            res0      = tok;
            res0.last = 1'b1;
            push_cnt  = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            accum_reg <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            win_reg   <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_COL_BITS'(1);
            col_reg   <= LINE_COL_BITS'(1);
        end else if (s_acc) begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            win_reg   <= win_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_acc) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
            count_next  = count_next + QCNT_W'(push_cnt);
        end
        if (m_acc) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (s_acc && push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head     = queue_reg[rd_ptr_reg];
    assign s_tready = count_reg <= QCNT_W'(QDEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = M_DATA_W'({head.chr, head.col, head.line, head.len,
                                 head.start, head.ival});
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_eoi_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> pos_reg == '0 && mode_reg == M_IDLE
                             && line_reg == LINE_COL_BITS'(1))
        else $error("scanner state not restarted after end of input");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == TK_EOF |-> m_tlast)
        else $error("eof beat without last");

    a_eoi_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> count_reg != '0)
        else $error("end of input produced no beat");
`endif

endmodule

`default_nettype wire
